/* rtl/u8enc_pkg.sv */
package u8enc_pkg;

  // map capacity and derived widths
  localparam int MAX_CHARS = 4096;
  localparam int MAP_DEPTH = MAX_CHARS + 1;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);
  localparam int CNT_W     = $clog2(MAX_CHARS + 1);
  localparam int LU_W      = $clog2(MAX_CHARS + 2);

  // fixed field widths
  localparam int BYTE_W = 15;
  localparam int IDX_W  = 13;
  localparam logic [BYTE_W:0] BYTE_LIMIT = 16'h7FFF;

  typedef enum logic [1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [31:0]        code_point;
    logic [BYTE_W-1:0]  query_byte;
  } req_t;

  typedef struct packed {
    logic [7:0]         utf8_byte;
    logic               byte_valid;
    logic               run_last;
    logic [IDX_W-1:0]   char_index;
    logic [BYTE_W-1:0]  byte_count;
    logic               overflow;
  } rsp_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;     // bytes[0] goes out first
    logic [1:0]      n_minus1;  // byte count minus one
  } enc_t;

  // UTF-8 encoding with replacement of surrogates and out-of-range values
  function automatic enc_t utf8_encode(input logic [31:0] cp);
    logic [20:0] c;
    enc_t        e;
    if (cp >= 32'h110000 || (cp >= 32'hD800 && cp <= 32'hDFFF)) begin
      c = 21'h00FFFD;
    end else begin
      c = cp[20:0];
    end
    e.bytes = '0;
    if (c < 21'h80) begin
      e.bytes[0] = c[7:0];
      e.n_minus1 = 2'd0;
    end else if (c < 21'h800) begin
      e.bytes[0] = 8'hC0 | {3'b000, c[10:6]};
      e.bytes[1] = 8'h80 | {2'b00, c[5:0]};
      e.n_minus1 = 2'd1;
    end else if (c < 21'h10000) begin
      e.bytes[0] = 8'hE0 | {4'h0, c[15:12]};
      e.bytes[1] = 8'h80 | {2'b00, c[11:6]};
      e.bytes[2] = 8'h80 | {2'b00, c[5:0]};
      e.n_minus1 = 2'd2;
    end else begin
      e.bytes[0] = 8'hF0 | {5'b00000, c[20:18]};
      e.bytes[1] = 8'h80 | {2'b00, c[17:12]};
      e.bytes[2] = 8'h80 | {2'b00, c[11:6]};
      e.bytes[3] = 8'h80 | {2'b00, c[5:0]};
      e.n_minus1 = 2'd3;
    end
    return e;
  endfunction

endpackage

/* rtl/u8enc_ram.sv */
module u8enc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/utf8_encoder_with_offset_map.sv */
// channel | signals                    | word  | direction
// req     | req_valid, req_stall, req  | req_t | into the block
// rsp     | rsp_valid, rsp_stall, rsp  | rsp_t | out of the block
//
// One request word at a time; req_stall is high while a word is in work.
// Clear and dropped append give one result word; an append gives one word per
// UTF-8 byte. A lookup is a binary search; each probe of the search is an
// address state and a compare state on the map RAM read. Reset clears the
// counters, the state and rsp_valid; map entry zero is decoded as zero, so the
// RAM needs no clearing pass. A stalled rsp holds S_ONE and S_BYTES in place.
module utf8_encoder_with_offset_map
  import u8enc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ONE,
    S_BYTES,
    S_LU_RD,
    S_LU_CMP
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  char_count;
  logic [BYTE_W-1:0] byte_total;
  enc_t              enc;
  logic [1:0]        byte_idx;
  rsp_t              one_word;
  logic [LU_W-1:0]   lo;
  logic [LU_W-1:0]   hi;
  logic [LU_W-1:0]   mid;
  logic [BYTE_W-1:0] query;

  logic              accept;
  logic              slot_free;
  logic              rsp_load;
  enc_t              enc_in;
  logic [BYTE_W:0]   total_sum;
  logic              drop;
  logic [LU_W-1:0]   mid_calc;
  logic [BYTE_W-1:0] map_rdata;
  logic [BYTE_W-1:0] probe_val;
  logic              map_we;
  logic [MAP_AW-1:0] map_waddr;
  logic [CNT_W-1:0]  count_inc;

  // single-result word: run_last set, no byte
  function automatic rsp_t one_rsp(input logic [IDX_W-1:0] idx,
                                   input logic [BYTE_W-1:0] cnt, input logic ovf);
    rsp_t r;
    r            = '0;
    r.run_last   = 1'b1;
    r.char_index = idx;
    r.byte_count = cnt;
    r.overflow   = ovf;
    return r;
  endfunction

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign slot_free = !rsp_valid || !rsp_stall;
  assign rsp_load  = slot_free && (state == S_ONE || state == S_BYTES);

  // append bookkeeping
  assign enc_in    = utf8_encode(req.code_point);
  assign total_sum = {1'b0, byte_total} + {14'd0, enc_in.n_minus1} + 16'd1;
  assign drop      = (char_count >= CNT_W'(MAX_CHARS)) || (total_sum > BYTE_LIMIT);
  assign count_inc = char_count + CNT_W'(1);
  assign map_we    = accept && (req.kind == KIND_APPEND) && !drop;
  assign map_waddr = MAP_AW'(count_inc);

  // search midpoint; entry zero always reads as zero
  assign mid_calc  = lo + ((hi - lo) >> 1);
  assign probe_val = (mid == '0) ? '0 : map_rdata;

  u8enc_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (total_sum[BYTE_W-1:0]),
    .raddr (MAP_AW'(mid_calc)),
    .rdata (map_rdata)
  );

  // sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      char_count <= '0;
      byte_total <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      // output valid: set on a load, cleared once taken
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req.kind)
              KIND_CLEAR: begin
                char_count <= '0;
                byte_total <= '0;
                one_word   <= one_rsp('0, '0, 1'b0);
                state      <= S_ONE;
              end
              KIND_APPEND: begin
                if (drop) begin
                  one_word <= one_rsp('0, byte_total, 1'b1);
                  state    <= S_ONE;
                end else begin
                  char_count <= count_inc;
                  byte_total <= total_sum[BYTE_W-1:0];
                  enc        <= enc_in;
                  byte_idx   <= 2'd0;
                  state      <= S_BYTES;
                end
              end
              KIND_LOOKUP: begin
                lo    <= '0;
                hi    <= LU_W'(char_count) + LU_W'(1);
                query <= req.query_byte;
                state <= S_LU_RD;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_ONE: begin
          if (slot_free) begin
            rsp   <= one_word;
            state <= S_IDLE;
          end
        end
        S_BYTES: begin
          if (slot_free) begin
            rsp.utf8_byte  <= enc.bytes[byte_idx];
            rsp.byte_valid <= 1'b1;
            rsp.run_last   <= (byte_idx == enc.n_minus1);
            rsp.char_index <= '0;
            rsp.byte_count <= byte_total;
            rsp.overflow   <= 1'b0;
            byte_idx       <= byte_idx + 2'd1;
            if (byte_idx == enc.n_minus1) begin
              state <= S_IDLE;
            end
          end
        end
        S_LU_RD: begin
          if (lo < hi) begin
            mid   <= mid_calc;
            state <= S_LU_CMP;
          end else begin
            one_word <= one_rsp(IDX_W'(lo), byte_total, 1'b0);
            state    <= S_ONE;
          end
        end
        S_LU_CMP: begin
          if (probe_val < query) begin
            lo <= mid + LU_W'(1);
          end else begin
            hi <= mid;
          end
          state <= S_LU_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // a stored append advances the character count by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    map_we |=> char_count == $past(count_inc))
    else $error("char_count did not advance on append");

  // the map is written only on an accepted append
  a_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    map_we |-> (req_valid && !req_stall && state == S_IDLE))
    else $error("map write outside an accepted append");

  // search bounds stay ordered
  a_search_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_LU_RD || state == S_LU_CMP) |-> lo <= hi)
    else $error("search bounds crossed");

  // a byte word never carries a lookup answer or an overflow flag
  a_byte_word: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.byte_valid) |-> (!rsp.overflow && rsp.char_index == '0))
    else $error("byte word carries lookup or overflow data");

  // a probe compares against the midpoint taken the cycle before
  a_probe_mid: assert property (@(posedge clk) disable iff (rst)
    (state == S_LU_CMP) |-> (mid == $past(mid_calc) && $past(state) == S_LU_RD))
    else $error("probe without a matching address cycle");
`endif

endmodule

/* test/utf8_encoder_with_offset_map_tb.sv */
module utf8_encoder_with_offset_map_tb
  import u8enc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT  = 200_000;
  localparam int TAIL_WAIT  = 40;
  localparam int RAND_WORDS = 210;
  localparam int TOP_QUERY  = 16384;

  typedef struct {
    req_t w;
    bit   drain;   // hold this word back until every due result has arrived
  } pend_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // pending request words and result words still due
  pend_t word_q[$];
  rsp_t  rsp_due_q[$];

  // predicted block state, advanced on each accepted request word
  int          seen_chars = 0;
  int          seen_bytes = 0;
  logic [14:0] byte_map [0:MAX_CHARS];

  // state tracked while planning, used to aim lookups at real offsets
  int plan_chars = 0;
  int plan_bytes = 0;
  int plan_off [0:MAX_CHARS];
  bit drain_next = 1'b0;

  int words_planned = 0;
  int words_sent    = 0;
  int rsp_seen      = 0;
  int bad_count     = 0;
  int cycle_cnt     = 0;

  int gap_left   = 0;
  int drv_count  = 0;
  bit drv_calm   = 1'b0;
  int stall_left = 0;
  int hold_left  = 0;
  bit mon_calm   = 1'b0;

  utf8_encoder_with_offset_map u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // UTF-8 bytes of one code point, invalid values replaced by U+FFFD
  function automatic int utf8_pack(input logic [31:0] cp, output logic [3:0][7:0] b);
    logic [31:0] c;
    if (cp >= 32'h110000 || (cp >= 32'hD800 && cp <= 32'hDFFF)) begin
      c = 32'hFFFD;
    end else begin
      c = cp;
    end
    b = '0;
    if (c < 32'h80) begin
      b[0] = c[7:0];
      return 1;
    end
    if (c < 32'h800) begin
      b[0] = 8'hC0 | {3'b000, c[10:6]};
      b[1] = 8'h80 | {2'b00, c[5:0]};
      return 2;
    end
    if (c < 32'h10000) begin
      b[0] = 8'hE0 | {4'h0, c[15:12]};
      b[1] = 8'h80 | {2'b00, c[11:6]};
      b[2] = 8'h80 | {2'b00, c[5:0]};
      return 3;
    end
    b[0] = 8'hF0 | {5'b00000, c[20:18]};
    b[1] = 8'h80 | {2'b00, c[17:12]};
    b[2] = 8'h80 | {2'b00, c[11:6]};
    b[3] = 8'h80 | {2'b00, c[5:0]};
    return 4;
  endfunction

  function automatic rsp_t make_rsp(input logic [7:0] ub, input logic bv, input logic last,
                                    input logic [12:0] idx, input logic [14:0] cnt,
                                    input logic ovf);
    rsp_t r;
    r.utf8_byte  = ub;
    r.byte_valid = bv;
    r.run_last   = last;
    r.char_index = idx;
    r.byte_count = cnt;
    r.overflow   = ovf;
    return r;
  endfunction

  // expected result words for one accepted request word
  task automatic predict_word(input req_t w);
    logic [3:0][7:0] b;
    int n;
    int lo;
    int hi;
    int mid;
    case (w.kind)
      KIND_CLEAR: begin
        seen_chars  = 0;
        seen_bytes  = 0;
        byte_map[0] = '0;
        rsp_due_q.insert(rsp_due_q.size(), make_rsp(8'h00, 1'b0, 1'b1, '0, '0, 1'b0));
      end
      KIND_APPEND: begin
        n = utf8_pack(w.code_point, b);
        if (seen_chars >= MAX_CHARS || seen_bytes + n > int'(BYTE_LIMIT)) begin
          // dropped: map full or byte total would overflow
          rsp_due_q.insert(rsp_due_q.size(),
                           make_rsp(8'h00, 1'b0, 1'b1, '0, 15'(seen_bytes), 1'b1));
        end else begin
          seen_bytes += n;
          seen_chars++;
          byte_map[seen_chars] = 15'(seen_bytes);
          for (int k = 0; k < n; k++) begin
            rsp_due_q.insert(rsp_due_q.size(),
                             make_rsp(b[k], 1'b1, k == n - 1, '0, 15'(seen_bytes), 1'b0));
          end
        end
      end
      KIND_LOOKUP: begin
        // lower bound over map entries 0..char count
        lo = 0;
        hi = seen_chars + 1;
        while (lo < hi) begin
          mid = lo + ((hi - lo) >> 1);
          if (byte_map[mid] < w.query_byte) begin
            lo = mid + 1;
          end else begin
            hi = mid;
          end
        end
        rsp_due_q.insert(rsp_due_q.size(),
                         make_rsp(8'h00, 1'b0, 1'b1, 13'(lo), 15'(seen_bytes), 1'b0));
      end
      default: ;  // unused kind: no result, no state change
    endcase
  endtask

  // queue one request word and track lengths for later lookup aiming
  task automatic plan(input kind_t k, input logic [31:0] cp, input int q);
    pend_t p;
    logic [3:0][7:0] b;
    int n;
    p.w.kind       = k;
    p.w.code_point = cp;
    p.w.query_byte = 15'(q);
    p.drain        = drain_next;
    drain_next     = 1'b0;
    word_q.insert(word_q.size(), p);
    words_planned++;
    if (k == KIND_CLEAR) begin
      plan_chars = 0;
      plan_bytes = 0;
    end else if (k == KIND_APPEND) begin
      n = utf8_pack(cp, b);
      if (plan_chars < MAX_CHARS && plan_bytes + n <= int'(BYTE_LIMIT)) begin
        plan_bytes += n;
        plan_chars++;
        plan_off[plan_chars] = plan_bytes;
      end
    end
  endtask

  function automatic logic [31:0] pick_code_point();
    logic [31:0] edges [14];
    edges = '{32'h0, 32'h7F, 32'h80, 32'h7FF, 32'h800, 32'hD7FF, 32'hD800,
              32'hDFFF, 32'hE000, 32'hFFFF, 32'h10000, 32'h10FFFF, 32'h110000,
              32'hFFFFFFFF};
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return $urandom_range(0, 32'h7F);
      2: return $urandom_range(32'h80, 32'h7FF);
      3: return $urandom_range(32'h800, 32'hFFFF);
      4: return $urandom_range(32'h10000, 32'h10FFFF);
      5: return $urandom_range(32'hD800, 32'hDFFF);
      6: return $urandom_range(32'h110000, 32'hFFFFFFFF);
      default: return edges[$urandom_range(0, 13)];
    endcase
  endfunction

  function automatic int pick_query();
    int q;
    case ($urandom_range(0, 3))
      0: q = int'($urandom_range(0, TOP_QUERY));
      1: q = int'($urandom_range(0, plan_bytes + 2));
      2: q = plan_off[$urandom_range(0, plan_chars)] + int'($urandom_range(0, 2)) - 1;
      default: q = plan_bytes + int'($urandom_range(0, 1));
    endcase
    if (q < 0) q = 0;
    if (q > TOP_QUERY) q = TOP_QUERY;
    return q;
  endfunction

  task automatic note_bad(input string why, input rsp_t e, input rsp_t a);
    bad_count++;
    if (bad_count <= 10) begin
      $display("%0t %s: exp byte=%02h bv=%0d last=%0d idx=%0d cnt=%0d ovf=%0d",
               $realtime, why, e.utf8_byte, e.byte_valid, e.run_last, e.char_index,
               e.byte_count, e.overflow);
      $display("        got byte=%02h bv=%0d last=%0d idx=%0d cnt=%0d ovf=%0d",
               a.utf8_byte, a.byte_valid, a.run_last, a.char_index, a.byte_count,
               a.overflow);
    end
  endtask

  // request driver: predict on accept, then offer the next word after its gap
  always @(posedge clk) begin : drive
    logic  offer;
    pend_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!(req_valid && req_stall)) begin
      if (req_valid) begin
        predict_word(req);
        words_sent++;
      end
      offer = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (word_q.size() > 0 && !(word_q[0].drain && rsp_due_q.size() > 0)) begin
        nxt = word_q.pop_front();
        req <= nxt.w;
        offer = 1'b1;
        if (drv_count % 32 == 0) drv_calm = ($urandom_range(0, 2) == 0);
        drv_count++;
        gap_left = drv_calm ? 0 : int'($urandom_range(0, 8));
      end
      req_valid <= offer;
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin : watch
    rsp_t e;
    logic ok;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_seen++;
        if (rsp_due_q.size() == 0) begin
          note_bad("unexpected word", '0, rsp);
        end else begin
          e = rsp_due_q.pop_front();
          ok = (rsp.utf8_byte === e.utf8_byte) && (rsp.byte_valid === e.byte_valid) &&
               (rsp.run_last === e.run_last) && (rsp.char_index === e.char_index) &&
               (rsp.byte_count === e.byte_count) && (rsp.overflow === e.overflow);
          if (!ok) note_bad("mismatch", e, rsp);
        end
        if (rsp_seen % 32 == 0) mon_calm = ($urandom_range(0, 2) == 0);
        stall_left = mon_calm ? 0 : int'($urandom_range(0, 8));
        // one long hold-off so the block backs up into its input
        if (rsp_seen == 60) hold_left = 250;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("utf8_encoder_with_offset_map_tb: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int run;
    int pick;
    bit drained;
    int rand_words;
    drained     = 1'b0;
    rand_words  = 0;
    byte_map[0] = '0;
    @(negedge clk);
    while (rst) @(negedge clk);

    // directed: lookups on an empty paragraph, encoding boundaries, replacements
    plan(KIND_LOOKUP, $urandom, 0);
    plan(KIND_LOOKUP, $urandom, TOP_QUERY);
    plan(KIND_APPEND, 32'h0, 0);
    plan(KIND_APPEND, 32'h7F, 32767);
    plan(KIND_APPEND, 32'h80, 0);
    plan(KIND_APPEND, 32'h7FF, 0);
    plan(KIND_APPEND, 32'h800, 0);
    plan(KIND_APPEND, 32'hFFFF, 0);
    plan(KIND_APPEND, 32'h10000, 0);
    plan(KIND_APPEND, 32'h10FFFF, 0);
    plan(KIND_APPEND, 32'h110000, 0);
    plan(KIND_APPEND, 32'hD800, 0);
    plan(KIND_APPEND, 32'hDFFF, 0);
    plan(KIND_APPEND, 32'hFFFFFFFF, 0);
    plan(KIND_LOOKUP, 32'hFFFFFFFF, 0);
    plan(KIND_LOOKUP, 0, 1);
    plan(KIND_LOOKUP, 0, 3);
    plan(KIND_LOOKUP, 0, plan_bytes);
    plan(KIND_LOOKUP, 0, TOP_QUERY);
    plan(KIND_NONE, $urandom, $urandom_range(0, 32767));
    plan(KIND_CLEAR, $urandom, $urandom_range(0, 32767));
    plan(KIND_LOOKUP, 0, 0);
    plan(KIND_APPEND, 32'hE000, 0);

    // random paragraphs: appends with lookups aimed at recorded offsets
    while (rand_words < RAND_WORDS) begin
      if ($urandom_range(0, 3) != 0) begin
        plan(KIND_CLEAR, $urandom, $urandom_range(0, 32767));
        rand_words++;
      end
      run = $urandom_range(3, 20);
      repeat (run) begin
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
          plan(KIND_APPEND, pick_code_point(), $urandom_range(0, 32767));
          rand_words++;
        end else if (pick < 18) begin
          plan(KIND_LOOKUP, $urandom, pick_query());
          rand_words++;
        end else if (pick == 18) begin
          plan(KIND_NONE, $urandom, $urandom_range(0, 32767));
        end else begin
          plan(KIND_CLEAR, $urandom, $urandom_range(0, 32767));
          rand_words++;
        end
      end
      if (rand_words >= RAND_WORDS / 2 && !drained) begin
        drain_next = 1'b1;
        drained    = 1'b1;
      end
    end

    // drained tail: a run of four-byte characters, then lookups at both ends
    drain_next = 1'b1;
    plan(KIND_CLEAR, 0, 0);
    repeat (16) plan(KIND_APPEND, $urandom_range(32'h10000, 32'h10FFFF), 0);
    plan(KIND_APPEND, 32'h41, 0);
    plan(KIND_APPEND, pick_code_point(), 0);
    plan(KIND_LOOKUP, 0, TOP_QUERY);
    plan(KIND_LOOKUP, 0, TOP_QUERY - 1);
    plan(KIND_LOOKUP, 0, 0);
    plan(KIND_LOOKUP, 0, 1);
    plan(KIND_LOOKUP, 0, 4);
    repeat (8) plan(KIND_LOOKUP, $urandom, pick_query());
    plan(KIND_CLEAR, 0, 0);
    plan(KIND_APPEND, pick_code_point(), 0);
    plan(KIND_LOOKUP, 0, 1);

    while (words_sent < words_planned || rsp_due_q.size() != 0) @(negedge clk);
    repeat (TAIL_WAIT) @(negedge clk);
    if (bad_count == 0 && rsp_due_q.size() == 0) begin
      $display("utf8_encoder_with_offset_map_tb: PASS");
    end else begin
      $display("utf8_encoder_with_offset_map_tb: FAIL");
    end
    $finish;
  end

endmodule
